FILE: design/acfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acfr_pkg
// Constants and helper functions shared by the ACARS frame receiver.
// ----------------------------------------------------------------------------
package acfr_pkg;

    localparam int unsigned TEXT_LIMIT_DEF = 319;

    localparam int unsigned CFG_W  = 9;
    localparam int unsigned LEN_W  = 9;
    localparam int unsigned CRC_W  = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CHAR_W = 7;
    localparam int unsigned NB_W   = 4;

    localparam logic [CFG_W-1:0] MIN_LEN_RESET = 9'd22;
    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 9'd234;

    // Configuration register indexes.
    localparam logic CFG_MIN_LEN = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h1021;
    localparam logic [BYTE_W-1:0] PREAMBLE   = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_PLUS  = 8'hAB;
    localparam logic [BYTE_W-1:0] SYNC_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] SYN_BYTE   = 8'h16;
    localparam logic [BYTE_W-1:0] SOH_BYTE   = 8'h01;
    localparam logic [CHAR_W-1:0] ETX_CHAR   = 7'h03;
    localparam logic [CHAR_W-1:0] ETB_CHAR   = 7'h17;
    localparam logic [CHAR_W-1:0] CR_CHAR    = 7'h0D;
    localparam logic [CHAR_W-1:0] LF_CHAR    = 7'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'h20;
    localparam logic [CHAR_W-1:0] SUBST_CHAR = 7'h5F;

    localparam logic [NB_W-1:0] NB_BYTE     = 4'd8;
    localparam logic [NB_W-1:0] NB_PREAMBLE = 4'd6;
    localparam logic [NB_W-1:0] NB_GOOD     = 4'd0;
    localparam logic [NB_W-1:0] NB_OFFSET   = 4'd2;

    // Bit-serial CRC over one byte, data bits entering LSB first.
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        logic             top;
        crc = crc_in;
        for (int k = 0; k < BYTE_W; k++)
        begin
            top = crc[CRC_W-1];
            crc = {crc[CRC_W-2:0], data[k]};
            if (top)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // Position of the lowest zero bit, searched over bits 0 to 6; 7 if none.
    function automatic logic [2:0] first_zero(input logic [BYTE_W-1:0] data);
        logic [2:0] pos;
        logic       found;
        pos   = 3'd7;
        found = 1'b0;
        for (int k = 0; k < 7; k++)
        begin
            if (!found && !data[k])
            begin
                pos   = 3'(k);
                found = 1'b1;
            end
        end
        return pos;
    endfunction

    function automatic logic [CHAR_W-1:0] sanitize(input logic [CHAR_W-1:0] c);
        if (c < SPACE_CHAR && c != CR_CHAR && c != LF_CHAR)
        begin
            return SUBST_CHAR;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: design/acars_frame_receiver.sv
`default_nettype none
// Data path: the input register takes the byte, then the result register drives m_tdata.
// Throughput: one byte per cycle unless stalled; the input register, frame state
// and result register each advance once per byte, with the 8-bit CRC step unrolled.
// Reset: the frame state returns to preamble hunting, the counters and CRC clear,
// and the length window returns to 22 and 234 (exclusive).
// ----------------------------------------------------------------------------
// acars_frame_receiver
// Preamble alignment, sync check, text sanitizing and CRC-16 frame check for
// ACARS bytes delivered by a bit slicer.
// ----------------------------------------------------------------------------
module acars_frame_receiver
    import acfr_pkg::*;
#(
    parameter int unsigned TEXT_LIMIT = TEXT_LIMIT_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Input stream.
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,   // [3:0] next_bits, [4] bit_resync,
                                              // [11:5] char_value, [12] message_ok,
                                              // [21:13] message_length, [23:22] zero
    output logic                   m_tlast,   // message_done
    output logic                   m_tuser,   // char_valid
    // Configuration.
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam int unsigned CNT_W = $clog2(TEXT_LIMIT + 1);
    localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(TEXT_LIMIT);

    typedef enum logic [3:0] {
        S_HUNT, S_PRE, S_SYNA, S_SYNB, S_SYNC, S_SYND, S_SOH,
        S_TEXT, S_CRCA, S_CRCB, S_END
    } frame_state_t;

    frame_state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CRC_W-1:0] crc_reg, crc_next;
    logic [CFG_W-1:0] min_len_reg, max_len_reg;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              out_valid_reg;
    logic [NB_W-1:0]   nb_reg, nb_next;
    logic              rs_reg, rs_next;
    logic              cv_reg, cv_next;
    logic [CHAR_W-1:0] cval_reg, cval_next;
    logic              done_reg, done_next;
    logic              ok_reg, ok_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    logic             advance;
    logic [2:0]       zero_pos;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] soh_cnt;
    logic [CHAR_W-1:0] ch;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign zero_pos = first_zero(in_data_reg);
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign soh_cnt  = cnt_reg + CNT_W'(in_data_reg != SOH_BYTE);
    assign ch       = in_data_reg[CHAR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        nb_next    = NB_BYTE;
        rs_next    = 1'b0;
        cv_next    = 1'b0;
        cval_next  = '0;
        done_next  = 1'b0;
        ok_next    = 1'b0;
        len_next   = '0;
        case (state_reg)
            S_PRE:
            begin
                if (in_data_reg == PREAMBLE)
                begin
                    nb_next = NB_PREAMBLE;
                end
                else if (zero_pos < 3'd2)
                begin
                    // Preamble run too short: rejudged as a hunting byte.
                    state_next = S_HUNT;
                    rs_next    = 1'b1;
                end
                else if (zero_pos == 3'd2)
                begin
                    // Already aligned: this byte is the first sync byte.
                    state_next = S_SYNB;
                    cnt_next   = CNT_W'(in_data_reg != SYNC_PLUS);
                end
                else
                begin
                    state_next = S_SYNA;
                    cnt_next   = '0;
                    nb_next    = {1'b0, zero_pos} - NB_OFFSET;
                end
            end
            S_SYNA:
            begin
                cnt_next   = cnt_reg + CNT_W'(in_data_reg != SYNC_PLUS);
                state_next = S_SYNB;
            end
            S_SYNB:
            begin
                cnt_next   = cnt_reg + CNT_W'(in_data_reg != SYNC_STAR);
                state_next = S_SYNC;
            end
            S_SYNC:
            begin
                cnt_next   = cnt_reg + CNT_W'(in_data_reg != SYN_BYTE);
                state_next = S_SYND;
            end
            S_SYND:
            begin
                cnt_next   = cnt_reg + CNT_W'(in_data_reg != SYN_BYTE);
                state_next = S_SOH;
            end
            S_SOH:
            begin
                if (soh_cnt > CNT_W'(2))
                begin
                    // Sync failed: the byte is judged again while hunting.
                    cnt_next = soh_cnt;
                    if (in_data_reg == PREAMBLE)
                    begin
                        state_next = S_PRE;
                    end
                    else
                    begin
                        state_next = S_HUNT;
                        rs_next    = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_TEXT;
                    cnt_next   = '0;
                    crc_next   = '0;
                end
            end
            S_TEXT:
            begin
                crc_next = crc16_byte(crc_reg, in_data_reg);
                if (ch == ETX_CHAR || ch == ETB_CHAR)
                begin
                    state_next = S_CRCA;
                end
                else
                begin
                    cv_next   = 1'b1;
                    cval_next = sanitize(ch);
                    cnt_next  = cnt_inc;
                    if (cnt_inc >= LIMIT)
                    begin
                        // Text overflow drops the frame.
                        state_next = S_HUNT;
                        done_next  = 1'b1;
                        len_next   = LEN_W'(cnt_inc);
                        rs_next    = 1'b1;
                    end
                end
            end
            S_CRCA:
            begin
                crc_next   = crc16_byte(crc_reg, in_data_reg);
                state_next = S_CRCB;
            end
            S_CRCB:
            begin
                crc_next   = crc16_byte(crc_reg, in_data_reg);
                state_next = S_END;
            end
            S_END:
            begin
                state_next = S_HUNT;
                done_next  = 1'b1;
                len_next   = LEN_W'(cnt_reg);
                if (crc_reg == '0 &&
                    CMP_W'(cnt_reg) < CMP_W'(max_len_reg) &&
                    CMP_W'(cnt_reg) > CMP_W'(min_len_reg))
                begin
                    nb_next = NB_GOOD;
                    ok_next = 1'b1;
                end
                else
                begin
                    rs_next = 1'b1;
                end
            end
            default:
            begin
                if (in_data_reg == PREAMBLE)
                begin
                    state_next = S_PRE;
                end
                else
                begin
                    state_next = S_HUNT;
                    rs_next    = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_HUNT;
            cnt_reg       <= '0;
            crc_reg       <= '0;
            min_len_reg   <= MIN_LEN_RESET;
            max_len_reg   <= MAX_LEN_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MIN_LEN)
                begin
                    min_len_reg <= cfg_data;
                end
                else
                begin
                    max_len_reg <= cfg_data;
                end
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                cnt_reg       <= cnt_next;
                crc_reg       <= crc_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
        if (advance)
        begin
            nb_reg   <= nb_next;
            rs_reg   <= rs_next;
            cv_reg   <= cv_next;
            cval_reg <= cval_next;
            done_reg <= done_next;
            ok_reg   <= ok_next;
            len_reg  <= len_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, len_reg, ok_reg, cval_reg, rs_reg, nb_reg};
    assign m_tlast  = done_reg;
    assign m_tuser  = cv_reg;

    // A good frame is always a finished frame and asks for no resync.
    a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ok_reg |-> done_reg && !rs_reg && nb_reg == NB_GOOD)
        else $error("message_ok without a clean frame end");

    // Every frame end returns the receiver to hunting.
    a_done_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        advance && done_next |=> state_reg == S_HUNT)
        else $error("frame end did not return to hunting");

    // The text counter never passes the overflow limit.
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TEXT |-> cnt_reg < LIMIT)
        else $error("text counter beyond limit");

    // A result stays in place while the consumer stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule
`default_nettype wire
